[rtl/rars_pkg.sv]
// package: tree geometry constants and the shared command type for the range-add range-sum tree
package rars_pkg;
  localparam int MaxPositions = 1024;
  localparam int PosW = $clog2(MaxPositions);
  localparam int NodeW = PosW + 1;
  localparam int CountW = PosW + 1;
  localparam int DataW = 32;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUM = 1'b1
  } cmd_t;
endpackage

[rtl/rars_ram.sv]
// generic single-port ram with registered read
module rars_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/range_add_range_sum_tree.sv]
// top level: lazy range-add range-sum tree over memory-held nodes
// steps: each visited node is read and updated, a pending add is passed on to both children,
// and on an add each split node then rebuilds its sum from both children; a skipped node is
// only checked for overlap; an empty add returns to idle at once; a query strobes its sum when done
// throughput: one item at a time, next item taken as soon as busy drops; receiver cannot stall
// reset: synchronous active-low; a clearing pass zeroes both memories with busy
// high; element_count resets to 1024
module range_add_range_sum_tree (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [9:0]  in_range_start,
  input  logic [9:0]  in_range_end,
  input  logic signed [31:0] in_delta,
  output logic        out_valid,
  output logic signed [31:0] out_range_sum,
  input  logic        cfg_we,
  input  logic [10:0] cfg_element_count
);
  localparam int NW = rars_pkg::NodeW;
  localparam int PW = rars_pkg::PosW;
  localparam int DW = rars_pkg::DataW;
  localparam int CW = rars_pkg::CountW;
  localparam int Levels = PW + 1;
  localparam int LvW = $clog2(Levels + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_VISIT, S_RD, S_RDW, S_PUSH, S_CHILD, S_CRD, S_CRDW, S_CWR,
    S_RET, S_RRD, S_RRDW, S_RCOMB, S_DONE
  } state_t;

  // one stack frame per tree level: node, span, and which child is next
  typedef struct packed {
    logic [NW-1:0] node;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [1:0]    phase;
  } frame_t;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic cmd_r;
  logic [PW-1:0] a_r, b_r;
  logic [DW-1:0] d_r, acc_r;
  frame_t stk_r [Levels];
  logic [LvW-1:0] sp_r;
  logic [NW-1:0] clr_r;
  logic [DW-1:0] tag_r, sum_r, lsum_r;
  logic cidx_r;

  // ram ports
  logic s_we, p_we;
  logic [NW-1:0] s_addr, p_addr;
  logic [DW-1:0] s_wd, p_wd, s_rd, p_rd;

  rars_ram #(.Width(DW), .Depth(2 ** NW)) u_sum_ram (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
  rars_ram #(.Width(DW), .Depth(2 ** NW)) u_tag_ram (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));

  frame_t top;
  logic [PW-1:0] mid;
  logic [DW-1:0] span;
  logic full_cover, disjoint;
  logic [CW-1:0] cnt_c;
  logic [PW-1:0] b_clip;
  logic empty_c;
  logic [NW-1:0] child;

  always_comb begin
    top = stk_r[sp_r[LvW-1:0]];
    mid = top.lo + ((top.hi - top.lo) >> 1);
    span = DW'({1'b0, top.hi} - {1'b0, top.lo} + (PW + 1)'(1));
    full_cover = (a_r <= top.lo) && (top.hi <= b_r);
    disjoint = (top.hi < a_r) || (b_r < top.lo);
    cnt_c = (count_r > CW'(rars_pkg::MaxPositions)) ? CW'(rars_pkg::MaxPositions) : count_r;
    b_clip = (CW'(in_range_end) > cnt_c - CW'(1)) ? PW'(cnt_c - CW'(1)) : in_range_end;
    empty_c = (cnt_c == '0) || (in_range_start > b_clip);
    child = {top.node[NW-2:0], cidx_r};
  end

  // child sum seen by parent: child ram sum plus its pending tag times span
  logic [PW-1:0] clo, chi;
  logic [DW-1:0] cspan;
  logic [DW-1:0] ceff;
  always_comb begin
    clo = cidx_r ? mid + PW'(1) : top.lo;
    chi = cidx_r ? top.hi : mid;
    cspan = DW'({1'b0, chi} - {1'b0, clo} + (PW + 1)'(1));
    ceff = s_rd + cspan * p_rd;
  end

  // memory port control
  always_comb begin
    s_we = 1'b0; p_we = 1'b0;
    s_addr = top.node; p_addr = top.node;
    s_wd = '0; p_wd = '0;
    case (state_r)
      S_CLEAR: begin
        s_we = 1'b1; p_we = 1'b1; s_addr = clr_r; p_addr = clr_r;
      end
      S_PUSH: begin
        // apply pending tag plus new delta if fully covered (add)
        s_we = 1'b1; p_we = 1'b1;
        s_wd = s_rd + span * ((full_cover && cmd_r == rars_pkg::CMD_ADD) ? p_rd + d_r : p_rd);
        p_wd = '0;
      end
      S_CRD, S_CRDW: begin
        p_addr = child;
      end
      S_CWR: begin
        p_we = 1'b1; p_addr = child; p_wd = p_rd + tag_r;
      end
      S_RRD, S_RRDW: begin
        s_addr = child; p_addr = child;
      end
      S_RCOMB: begin
        // parent sum is written once both children are in
        s_we = cidx_r; s_wd = lsum_r + ceff;
      end
      default: ;
    endcase
  end

  logic [DW-1:0] node_tag_c;
  assign node_tag_c = (full_cover && cmd_r == rars_pkg::CMD_ADD) ? p_rd + d_r : p_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      count_r <= CW'(rars_pkg::MaxPositions);
      out_valid <= 1'b0;
      sp_r <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) count_r <= cfg_element_count;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + NW'(1);
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_r <= in_command; a_r <= in_range_start; b_r <= b_clip;
            d_r <= in_delta; acc_r <= '0; sp_r <= '0;
            stk_r[0] <= '{node: NW'(1), lo: '0, hi: '1, phase: 2'd0};
            if (empty_c) state_r <= (in_command == rars_pkg::CMD_SUM) ? S_DONE : S_IDLE;
            else state_r <= S_VISIT;
          end
        end
        S_VISIT: begin
          if (disjoint) state_r <= S_RET;
          else state_r <= S_RD;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: state_r <= S_PUSH;
        S_PUSH: begin
          tag_r <= node_tag_c;
          sum_r <= s_wd;
          cidx_r <= 1'b0;
          if (top.lo != top.hi && node_tag_c != '0) state_r <= S_CRD;
          else if (full_cover || top.lo == top.hi) begin
            if (cmd_r == rars_pkg::CMD_SUM) acc_r <= acc_r + s_wd;
            state_r <= S_RET;
          end else state_r <= S_CHILD;
        end
        S_CRD: state_r <= S_CRDW;
        S_CRDW: state_r <= S_CWR;
        S_CWR: begin
          cidx_r <= 1'b1;
          if (!cidx_r) state_r <= S_CRD;
          else if (full_cover) begin
            if (cmd_r == rars_pkg::CMD_SUM) acc_r <= acc_r + sum_r;
            state_r <= S_RET;
          end else state_r <= S_CHILD;
        end
        S_CHILD: begin
          // descend into next child per phase; once both are done, rebuild the sum on an add or return
          if (top.phase == 2'd2) begin
            if (cmd_r == rars_pkg::CMD_ADD) begin
              cidx_r <= 1'b0; state_r <= S_RRD;
            end else state_r <= S_RET;
          end else begin
            stk_r[sp_r] <= '{node: top.node, lo: top.lo, hi: top.hi,
                             phase: top.phase + 2'd1};
            stk_r[sp_r + LvW'(1)] <= (top.phase == 2'd0) ?
              '{node: {top.node[NW-2:0], 1'b0}, lo: top.lo, hi: mid, phase: 2'd0} :
              '{node: {top.node[NW-2:0], 1'b1}, lo: mid + PW'(1), hi: top.hi, phase: 2'd0};
            sp_r <= sp_r + LvW'(1);
            state_r <= S_VISIT;
          end
        end
        S_RRD: state_r <= S_RRDW;
        S_RRDW: state_r <= S_RCOMB;
        S_RCOMB: begin
          // a skipped child may still hold a pending add, so take the tag-inclusive sum
          if (!cidx_r) begin
            lsum_r <= ceff;
            cidx_r <= 1'b1; state_r <= S_RRD;
          end else state_r <= S_RET;
        end
        S_RET: begin
          if (sp_r == '0) state_r <= (cmd_r == rars_pkg::CMD_SUM) ? S_DONE : S_IDLE;
          else begin
            sp_r <= sp_r - LvW'(1);
            state_r <= S_CHILD;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_range_sum <= acc_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

[sim/tb_range_add_range_sum_tree.sv]
// testbench for the range-add range-sum tree: directed and random items against a flat-array predictor
module tb_range_add_range_sum_tree;
  timeunit 1ns;
  timeprecision 1ps;

  // item as queued for the driver
  typedef struct {
    rars_pkg::cmd_t                  command;
    logic [rars_pkg::PosW-1:0]       range_start;
    logic [rars_pkg::PosW-1:0]       range_end;
    logic [rars_pkg::DataW-1:0]      delta;
  } tree_item_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic [9:0]        in_range_start;
  logic [9:0]        in_range_end;
  logic signed [31:0] in_delta;
  logic              out_valid;
  logic signed [31:0] out_range_sum;
  logic              cfg_we;
  logic [10:0]       cfg_element_count;

  range_add_range_sum_tree i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .in_delta          (in_delta),
    .out_valid         (out_valid),
    .out_range_sum     (out_range_sum),
    .cfg_we            (cfg_we),
    .cfg_element_count (cfg_element_count)
  );

  // predictor state: a flat array gives the same wrapped sums as the tree
  logic [rars_pkg::DataW-1:0]  position_vals [rars_pkg::MaxPositions];
  logic [rars_pkg::CountW-1:0] live_count;

  tree_item_t        pending_items [$];
  logic [rars_pkg::DataW-1:0]  expected_sums [$];
  int                error_count;
  int                accepted_items;
  int                sums_seen;
  bit                driver_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // a generous fixed limit: about 2000 items plus gaps, several times over
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // apply one accepted item to the predictor; queries push their expected sum
  task automatic predict_item(input tree_item_t it);
    int unsigned cnt;
    int unsigned lo;
    int unsigned hi;
    logic [rars_pkg::DataW-1:0] acc;
    cnt = live_count;
    if (cnt > rars_pkg::MaxPositions) cnt = rars_pkg::MaxPositions;
    lo  = it.range_start;
    hi  = it.range_end;
    acc = '0;
    if (cnt != 0 && hi > cnt - 1) hi = cnt - 1;
    if (cnt != 0 && lo <= hi) begin
      for (int p = lo; p <= hi; p++) begin
        if (it.command == rars_pkg::CMD_ADD) position_vals[p] += it.delta;
        else acc += position_vals[p];
      end
    end
    if (it.command == rars_pkg::CMD_SUM) expected_sums.push_back(acc);
  endtask

  // driver: bursts of items with random gaps between them
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      // item taken at this edge
      if (start && !busy) begin
        predict_item(pending_items.pop_front());
        accepted_items++;
      end
      if (start && busy) begin
        // hold the item until the block takes it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (driver_on && pending_items.size() > 0) begin
        tree_item_t nx;
        nx = pending_items[0];
        start          <= 1'b1;
        in_command     <= nx.command;
        in_range_start <= nx.range_start;
        in_range_end   <= nx.range_end;
        in_delta       <= nx.delta;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          // no gap about a third of the time
          gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(60, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed sum is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sums_seen++;
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected sum %0d", out_range_sum));
      end else begin
        logic [rars_pkg::DataW-1:0] want;
        want = expected_sums.pop_front();
        if (out_range_sum !== want)
          report_mismatch($sformatf("range_sum got %0d want %0d",
                                    out_range_sum, $signed(want)));
      end
    end
  end

  function automatic tree_item_t make_item(rars_pkg::cmd_t c, int unsigned a, int unsigned b,
                                           logic [rars_pkg::DataW-1:0] d);
    tree_item_t it;
    it.command     = c;
    it.range_start = 10'(a);
    it.range_end   = 10'(b);
    it.delta       = d;
    return it;
  endfunction

  // random item: mostly short ranges so sums stay cheap, some wide or reversed
  function automatic tree_item_t rand_item(int unsigned span);
    int unsigned a;
    int unsigned b;
    logic [rars_pkg::DataW-1:0] d;
    a = $urandom_range(span - 1, 0);
    case ($urandom_range(9, 0))
      0:       b = $urandom_range(rars_pkg::MaxPositions - 1, 0);
      1:       b = (a == 0) ? 0 : $urandom_range(a - 1, 0);
      2:       b = rars_pkg::MaxPositions - 1;
      default: b = (a + $urandom_range(40, 0) > rars_pkg::MaxPositions - 1)
                   ? rars_pkg::MaxPositions - 1 : a + $urandom_range(40, 0);
    endcase
    case ($urandom_range(3, 0))
      0:       d = $urandom();
      1:       d = $urandom_range(15, 0) - 8;
      2:       d = {$urandom_range(1, 0) ? 1'b1 : 1'b0,
                    {(rars_pkg::DataW - 1){$urandom_range(1, 0) == 1}}};
      default: d = $urandom_range(1000, 0);
    endcase
    return make_item($urandom_range(1, 0) ? rars_pkg::CMD_SUM : rars_pkg::CMD_ADD, a, b, d);
  endfunction

  // wait until every item is taken, all sums are in and the block is idle
  task automatic drain_block;
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned value);
    @(posedge clk);
    cfg_we            <= 1'b1;
    cfg_element_count <= 11'(value);
    @(posedge clk);
    cfg_we            <= 1'b0;
    live_count        = 11'(value);
  endtask

  initial begin
    int unsigned counts [7];
    counts = '{1, 0, 1024, 2047, 7, 1025, 300};
    rst_n             = 1'b0;
    start             = 1'b0;
    in_command        = rars_pkg::CMD_ADD;
    in_range_start    = '0;
    in_range_end      = '0;
    in_delta          = '0;
    cfg_we            = 1'b0;
    cfg_element_count = 11'd1024;
    error_count       = 0;
    accepted_items    = 0;
    sums_seen         = 0;
    driver_on         = 1'b0;
    live_count        = 11'd1024;
    foreach (position_vals[i]) position_vals[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed part: initial array as single-position adds, extremes, empty ranges
    for (int p = 0; p < 6; p++)
      pending_items.push_back(make_item(rars_pkg::CMD_ADD, p, p, p * 3 - 5));
    pending_items.push_back(make_item(rars_pkg::CMD_ADD, 0, 1023, 32'h7fff_ffff));
    pending_items.push_back(make_item(rars_pkg::CMD_ADD, 1023, 1023, 32'h8000_0000));
    pending_items.push_back(make_item(rars_pkg::CMD_SUM, 0, 1023, 32'hffff_ffff));
    pending_items.push_back(make_item(rars_pkg::CMD_SUM, 1023, 1023, 0));
    pending_items.push_back(make_item(rars_pkg::CMD_SUM, 0, 0, 0));
    pending_items.push_back(make_item(rars_pkg::CMD_SUM, 5, 2, 0));
    pending_items.push_back(make_item(rars_pkg::CMD_ADD, 9, 3, 32'h1234_5678));
    pending_items.push_back(make_item(rars_pkg::CMD_ADD, 511, 512, 32'hffff_ffff));
    pending_items.push_back(make_item(rars_pkg::CMD_SUM, 510, 513, 0));
    pending_items.push_back(make_item(rars_pkg::CMD_SUM, 0, 1023, 0));
    driver_on = 1'b1;
    drain_block();

    // phases through several element counts, the extremes among them
    foreach (counts[k]) begin
      write_count(counts[k]);
      pending_items.push_back(make_item(rars_pkg::CMD_SUM, 0, 1023, 0));
      pending_items.push_back(make_item(rars_pkg::CMD_ADD, 0, 1023, 32'h0000_0003));
      pending_items.push_back(make_item(rars_pkg::CMD_SUM, 1023, 1023, 0));
      for (int n = 0; n < 270; n++)
        pending_items.push_back(rand_item(($urandom_range(3, 0) == 0) ? rars_pkg::MaxPositions
                                          : ((counts[k] == 0) ? 8
                                          : (counts[k] > rars_pkg::MaxPositions
                                             ? rars_pkg::MaxPositions : counts[k]))));
      drain_block();
    end

    if (expected_sums.size() != 0)
      report_mismatch("sums still expected at the end");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
